// ===== rtl/core/gfe_pkg.sv =====
// Shared types, fixed-point constants and the arctangent table of the GPS fix projector.
package gfe_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DATUM_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATUM_LON = 2'd1;

    // Field widths
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int EAST_W  = 37;
    localparam int NORTH_W = 36;
    localparam int COS_W   = 31;

    // Millimetres per 1e-7 degree, Q32
    localparam logic [35:0] MM_PER_E7_Q32 = 36'd47757857342;

    // Output saturation magnitudes
    localparam logic [35:0] EAST_LIMIT  = 36'd40030174000;
    localparam logic [34:0] NORTH_LIMIT = 35'd20015087000;

    // CORDIC constants: inverse gain in Q30, unity in Q30, quarter turn in 1e-7 deg
    localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sh026DD3B6A;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] QUARTER_TURN_E7 = 31'd900000000;

    // Arctangent of 2^-i in 1e-7 degree units
    localparam logic [28:0] ATAN_E7 [32] = '{
        29'd450000000, 29'd265650512, 29'd140362435, 29'd71250163, 29'd35763344,
        29'd17899106, 29'd8951737, 29'd4476142, 29'd2238105, 29'd1119057,
        29'd559529, 29'd279765, 29'd139882, 29'd69941, 29'd34971, 29'd17485,
        29'd8743, 29'd4371, 29'd2186, 29'd1093, 29'd546, 29'd273, 29'd137,
        29'd68, 29'd34, 29'd17, 29'd9, 29'd4, 29'd2, 29'd1, 29'd1, 29'd0
    };

    // Serial multiplier geometry: multiplier operand bits, multiplicand bits
    localparam int MUL_A_W   = 40;
    localparam int MUL_M_W   = 36;
    localparam int MUL_P_W   = MUL_A_W + MUL_M_W;
    localparam int MUL_CNT_W = $clog2(MUL_A_W);

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] opa;
        logic [MUL_M_W-1:0] opm;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [LAT_W-1:0] angle;
    } cordic_req_t;

endpackage

// ===== rtl/core/gfe_mul.sv =====
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module gfe_mul
    import gfe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  mul_req_t           req,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MUL_M_W-1:0]   acc_reg, acc_next;
    logic [MUL_A_W-1:0]   lo_reg, lo_next;
    logic [MUL_M_W-1:0]   m_reg, m_next;
    logic [MUL_M_W:0]     sum;

    // Partial sum of the high half and the selected multiplicand
    assign sum = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, m_reg} : '0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        lo_next   = lo_reg;
        m_next    = m_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            lo_next   = req.opa;
            m_next    = req.opm;
        end else if (busy_reg) begin
            // add then shift the whole product right by one
            acc_next = sum[MUL_M_W:1];
            lo_next  = {sum[0], lo_reg[MUL_A_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_A_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        lo_reg  <= lo_next;
        m_reg   <= m_next;
    end

    assign done    = done_reg;
    assign product = {acc_reg, lo_reg};

endmodule

// ===== rtl/core/gfe_cordic.sv =====
// Rotation-mode CORDIC giving the Q1.30 cosine of a latitude, one iteration per cycle.
module gfe_cordic
    import gfe_pkg::*;
#(
    parameter int STEPS = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cordic_req_t      req,
    output logic             done,
    output logic [COS_W-1:0] cosine
);

    localparam int CW = $clog2(STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        i_reg, i_next;
    logic signed [32:0]   x_reg, x_next;
    logic signed [32:0]   y_reg, y_next;
    logic signed [31:0]   z_reg, z_next;
    logic [LAT_W-1:0]     mag;
    logic signed [32:0]   dx, dy;
    logic signed [31:0]   at;

    // |angle|; clamped to a quarter turn when it is loaded into z
    assign mag = req.angle[LAT_W-1] ? (~req.angle + 1'b1) : req.angle;

    // Arithmetic shifts round toward minus infinity
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = $signed({3'b000, ATAN_E7[5'(i_reg)]});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        i_next    = i_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (req.start) begin
            busy_next = 1'b1;
            i_next    = '0;
            x_next    = CORDIC_INV_GAIN;
            y_next    = '0;
            z_next    = (mag > QUARTER_TURN_E7) ? {1'b0, QUARTER_TURN_E7} : {1'b0, mag};
        end else if (busy_reg) begin
            if (!z_reg[31]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            if (i_reg == CW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                i_next = i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        i_reg <= i_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Clamp to [0, 1.0]
    always_comb begin
        if (x_reg[32]) begin
            cosine = '0;
        end else if (x_reg[31:0] > {1'b0, ONE_Q30}) begin
            cosine = ONE_Q30;
        end else begin
            cosine = x_reg[30:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/core/gps_fix_to_local_enu.sv =====
// Top level: GPS fix to local east/north offsets in millimetres.
//
// A fix is taken when s_ready is high, which it is whenever no other fix is in work. A fix
// with a negative status is dropped in the cycle it is taken and leaves the block free. A
// valid fix goes from acceptance to a loaded result in these steps: the differences are
// formed and registered, three products are formed in turn on the bit-serial multiplier
// (north, dlon times cosine, east), each by a start pulse, an operand load and the
// 40 multiplier bits, and the output register is loaded. The next fix can be taken in the
// cycle after the load. When a nonzero datum is set, or for the first fix that becomes the
// origin, the CORDIC cosine is computed before the products. If the previous result has
// not yet been taken, the new one waits until it has. The result waits in an output
// register, so the next fix is accepted and worked on while it is still to be taken.
// Datum writes go to a separate write channel, always ready, and must happen while idle.
module gps_fix_to_local_enu
    import gfe_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]               cfg_data,
    // fix input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [2:0]         s_fix_status,
    input  logic signed [LAT_W-1:0]   s_latitude_e7,
    input  logic signed [LON_W-1:0]   s_longitude_e7,
    // offset output
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [EAST_W-1:0]  m_east_mm,
    output logic signed [NORTH_W-1:0] m_north_mm
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_COS, ST_NORTH, ST_PROD, ST_EAST, ST_DONE
    } state_t;

    state_t                   state_reg;
    logic signed [LAT_W-1:0]  base_lat_reg;
    logic signed [LON_W-1:0]  base_lon_reg;
    logic                     origin_valid_reg;
    logic signed [LAT_W-1:0]  origin_lat_reg;
    logic signed [LON_W-1:0]  origin_lon_reg;
    logic [COS_W-1:0]         origin_cos_reg;
    logic signed [LAT_W-1:0]  lat_reg, olat_reg;
    logic signed [LON_W-1:0]  lon_reg, olon_reg;
    logic                     need_cos_reg, latch_cos_reg;
    logic [COS_W-1:0]         cos_reg;
    logic [31:0]              dlat_mag_reg, dlon_mag_reg;
    logic                     dlat_neg_reg, dlon_neg_reg;
    logic [36:0]              north_raw_reg, east_raw_reg;
    logic [MUL_A_W-1:0]       p_reg;
    logic                     mul_start_reg, cordic_start_reg;
    logic                     m_valid_reg;
    logic signed [EAST_W-1:0] m_east_reg;
    logic signed [NORTH_W-1:0] m_north_reg;

    logic                     datum_set;
    logic signed [31:0]       dlat;
    logic signed [32:0]       dlon;
    logic [31:0]              dlat_mag;
    logic [31:0]              dlon_mag;
    logic [34:0]              north_sat;
    logic [35:0]              east_sat;
    logic signed [NORTH_W-1:0] north_val;
    logic signed [EAST_W-1:0] east_val;
    mul_req_t                 mul_req;
    logic                     mul_done;
    logic [MUL_P_W-1:0]       mul_prod;
    cordic_req_t              cordic_req;
    logic                     cordic_done;
    logic [COS_W-1:0]         cordic_cos;

    assign datum_set = (base_lat_reg != '0) || (base_lon_reg != '0);

    // Differences from the origin and their magnitudes
    assign dlat     = 32'(lat_reg) - 32'(olat_reg);
    assign dlon     = 33'(lon_reg) - 33'(olon_reg);
    assign dlat_mag = dlat[31] ? 32'(-dlat) : 32'(dlat);
    assign dlon_mag = dlon[32] ? 32'(-dlon) : dlon[31:0];

    // Saturate magnitudes, then reapply the signs
    assign north_sat = (north_raw_reg > 37'(NORTH_LIMIT)) ? NORTH_LIMIT : north_raw_reg[34:0];
    assign east_sat  = (east_raw_reg > 37'(EAST_LIMIT)) ? EAST_LIMIT : east_raw_reg[35:0];
    assign north_val = dlat_neg_reg ? -$signed({1'b0, north_sat}) : $signed({1'b0, north_sat});
    assign east_val  = dlon_neg_reg ? -$signed({1'b0, east_sat}) : $signed({1'b0, east_sat});

    // Multiplier operands follow the product being formed
    always_comb begin
        mul_req.start = mul_start_reg;
        unique case (state_reg)
            ST_PROD: begin
                mul_req.opa = MUL_A_W'(dlon_mag_reg);
                mul_req.opm = MUL_M_W'(cos_reg);
            end
            ST_EAST: begin
                mul_req.opa = p_reg;
                mul_req.opm = MM_PER_E7_Q32;
            end
            default: begin
                mul_req.opa = MUL_A_W'(dlat_mag_reg);
                mul_req.opm = MM_PER_E7_Q32;
            end
        endcase
    end

    assign cordic_req.start = cordic_start_reg;
    assign cordic_req.angle = olat_reg;

    gfe_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    gfe_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cordic_req),
        .done    (cordic_done),
        .cosine  (cordic_cos)
    );

    // Sequencer, configuration registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            base_lat_reg     <= '0;
            base_lon_reg     <= '0;
            origin_valid_reg <= 1'b0;
            mul_start_reg    <= 1'b0;
            cordic_start_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // one-cycle start pulses for the CORDIC and the multiplier
            cordic_start_reg <= (state_reg == ST_PREP) && need_cos_reg;
            mul_start_reg    <= ((state_reg == ST_PREP) && !need_cos_reg) ||
                                ((state_reg == ST_COS) && cordic_done) ||
                                (((state_reg == ST_NORTH) || (state_reg == ST_PROD)) &&
                                 mul_done);

            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_DATUM_LAT: base_lat_reg <= cfg_data[LAT_W-1:0];
                    REG_DATUM_LON: base_lon_reg <= cfg_data;
                    default: ;
                endcase
            end

            // taken result empties the output register unless a new one is loaded
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && !s_fix_status[2]) begin
                        lat_reg <= s_latitude_e7;
                        lon_reg <= s_longitude_e7;
                        if (datum_set) begin
                            olat_reg      <= base_lat_reg;
                            olon_reg      <= base_lon_reg;
                            need_cos_reg  <= 1'b1;
                            latch_cos_reg <= 1'b0;
                        end else if (!origin_valid_reg) begin
                            // first valid fix becomes the origin
                            olat_reg         <= s_latitude_e7;
                            olon_reg         <= s_longitude_e7;
                            origin_lat_reg   <= s_latitude_e7;
                            origin_lon_reg   <= s_longitude_e7;
                            origin_valid_reg <= 1'b1;
                            need_cos_reg     <= 1'b1;
                            latch_cos_reg    <= 1'b1;
                        end else begin
                            olat_reg      <= origin_lat_reg;
                            olon_reg      <= origin_lon_reg;
                            cos_reg       <= origin_cos_reg;
                            need_cos_reg  <= 1'b0;
                            latch_cos_reg <= 1'b0;
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    dlat_mag_reg <= dlat_mag;
                    dlat_neg_reg <= dlat[31];
                    dlon_mag_reg <= dlon_mag;
                    dlon_neg_reg <= dlon[32];
                    if (need_cos_reg) begin
                        state_reg <= ST_COS;
                    end else begin
                        state_reg <= ST_NORTH;
                    end
                end
                ST_COS: begin
                    if (cordic_done) begin
                        cos_reg <= cordic_cos;
                        if (latch_cos_reg) begin
                            origin_cos_reg <= cordic_cos;
                        end
                        state_reg <= ST_NORTH;
                    end
                end
                ST_NORTH: begin
                    // round(|dlat| * K / 2^32)
                    if (mul_done) begin
                        north_raw_reg <= {1'b0, mul_prod[67:32]} + 37'(mul_prod[31]);
                        state_reg     <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    // |dlon| * cos in Q8 units of 1e-7 degree
                    if (mul_done) begin
                        p_reg     <= mul_prod[61:22];
                        state_reg <= ST_EAST;
                    end
                end
                ST_EAST: begin
                    // round(p * K / 2^40)
                    if (mul_done) begin
                        east_raw_reg <= {1'b0, mul_prod[75:40]} + 37'(mul_prod[39]);
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_east_reg  <= east_val;
                        m_north_reg <= north_val;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_east_mm  = m_east_reg;
    assign m_north_mm = m_north_reg;

endmodule

// ===== rtl/core/gfe_checker.sv =====
// Port-level checker for the GPS fix projector, with its bind to the top level.
module gfe_checker
    import gfe_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic signed [2:0]         s_fix_status,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [EAST_W-1:0]  m_east_mm,
    input logic signed [NORTH_W-1:0] m_north_mm
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_east_mm) && $stable(m_north_mm))
        else $error("stalled result changed");

    // A valid fix occupies the block
    a_fix_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_fix_status[2] |=> !s_ready)
        else $error("block free right after a valid fix");

    // A dropped fix leaves the block free
    a_drop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_fix_status[2] |=> s_ready)
        else $error("dropped fix stalled the input");

    // Offsets stay within the saturation limits
    a_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            ($signed(m_east_mm) <= $signed({1'b0, EAST_LIMIT})) &&
            ($signed(m_east_mm) >= -$signed({1'b0, EAST_LIMIT})) &&
            ($signed(m_north_mm) <= $signed({1'b0, NORTH_LIMIT})) &&
            ($signed(m_north_mm) >= -$signed({1'b0, NORTH_LIMIT})))
        else $error("offset beyond saturation limit");

endmodule

bind gps_fix_to_local_enu gfe_checker u_gfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_fix_status (s_fix_status),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_east_mm    (m_east_mm),
    .m_north_mm   (m_north_mm)
);
